### design/msp_pkg.sv
// ----------------------------------------------------------------------------
// Motor start protection package
// Shared types, codes and the sensor wiring map of the motor start
// protection unit.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int MAX_MOTORS     = 8;
  localparam int SENSOR_BITS    = 24;
  localparam int FAULT_BASE_BIT = 22;
  localparam int START_BITS     = 16;
  localparam int REG_BITS       = 64;

  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_SAMPLE = 3'd1;
  localparam logic [2:0] KIND_START  = 3'd2;
  localparam logic [2:0] KIND_STOP   = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  localparam logic [1:0] REG_PROTECTED_COUNT = 2'd0;
  localparam logic [1:0] REG_START_TIMES_LOW = 2'd1;
  localparam logic [1:0] REG_START_TIMES_HIGH = 2'd2;

  // Source bit of each permuted sensor bit.
  localparam logic [4:0] WIRING [SENSOR_BITS] = '{
    5'd5, 5'd6, 5'd7, 5'd3, 5'd2, 5'd1, 5'd0, 5'd12,
    5'd13, 5'd14, 5'd15, 5'd8, 5'd9, 5'd10, 5'd11, 5'd20,
    5'd21, 5'd22, 5'd23, 5'd19, 5'd18, 5'd17, 5'd16, 5'd4
  };

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_SAMPLE,
    CMD_START,
    CMD_STOP,
    CMD_CLEAR,
    CMD_NOP
  } cmd_op_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_FAIL = 2'd2
  } motor_mode_t;

  typedef struct packed {
    cmd_op_t                  op;
    logic [2:0]               motor_index;
    logic                     index_ok;
    logic [SENSOR_BITS-1:0]   sensors;
    logic [MAX_MOTORS-1:0]    fault_upd;
    logic [MAX_MOTORS-1:0]    fault_val;
  } cmd_t;

  typedef struct packed {
    logic [MAX_MOTORS-1:0]  motor_running;
    logic [MAX_MOTORS-1:0]  motor_failed;
    logic [SENSOR_BITS-1:0] sensor_word;
    logic                   sensors_changed;
    logic                   motors_changed;
  } result_t;

  function automatic logic [SENSOR_BITS-1:0] permute_sensors(
    input logic [SENSOR_BITS-1:0] raw
  );
    logic [SENSOR_BITS-1:0] w;
    w = '0;
    for (int b = 0; b < SENSOR_BITS; b++) begin
      w[b] = raw[WIRING[b]];
    end
    return w;
  endfunction

endpackage

### design/motor_start_protection_unit_core.sv
// ----------------------------------------------------------------------------
// Motor start protection unit
// Eight-channel motor start sequencing with speed-sensor protection.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while the request queue is not full
// and returns one result per request in order. A request accepted into the
// two-entry request queue is decoded on the way in; once the result queue
// has room, it is applied to the motor state and its result is pushed into
// a two-entry result queue at the same edge. The motor state engine updates
// all channels at once, which sets the sustained rate of one request per
// cycle while neither queue stalls. Configuration registers may be written
// only while no request is in flight.
module motor_start_protection_unit_core
  import msp_pkg::*;
#(
  parameter int MOTOR_COUNT = 8,
  parameter int TIME_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [2:0]             in_kind,
  input  logic [2:0]             in_motor_index,
  input  logic [SENSOR_BITS-1:0] in_raw_sensors,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [MAX_MOTORS-1:0]  out_motor_running,
  output logic [MAX_MOTORS-1:0]  out_motor_failed,
  output logic [SENSOR_BITS-1:0] out_sensor_word,
  output logic                   out_sensors_changed,
  output logic                   out_motors_changed,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [REG_BITS-1:0]    cfg_wdata
);

  logic [3:0]          prot_count_r;
  logic [REG_BITS-1:0] start_low_r;
  logic [REG_BITS-1:0] start_high_r;
  logic [3:0]          prot_n;
  cmd_t                front_cmd;
  cmd_t                back_cmd;
  logic [$bits(cmd_t)-1:0]    back_cmd_bits;
  logic                cmd_empty;
  logic                cmd_pop;
  logic                res_full;
  logic                res_push;
  result_t             back_res;
  result_t             out_res;
  logic [$bits(result_t)-1:0] out_res_bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prot_count_r <= '0;
      start_low_r  <= '0;
      start_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROTECTED_COUNT:  prot_count_r <= cfg_wdata[3:0];
        REG_START_TIMES_LOW:  start_low_r  <= cfg_wdata;
        REG_START_TIMES_HIGH: start_high_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign prot_n = (prot_count_r > 4'(MOTOR_COUNT)) ? 4'(MOTOR_COUNT) : prot_count_r;

  msp_front #(
    .MOTOR_COUNT(MOTOR_COUNT)
  ) u_front (
    .kind       (in_kind),
    .motor_index(in_motor_index),
    .raw_sensors(in_raw_sensors),
    .prot_n     (prot_n),
    .cmd        (front_cmd)
  );

  msp_queue #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(2)
  ) u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .push_data(front_cmd),
    .full     (in_full),
    .pop      (cmd_pop),
    .pop_data (back_cmd_bits),
    .empty    (cmd_empty)
  );

  assign back_cmd = cmd_t'(back_cmd_bits);

  msp_back #(
    .MOTOR_COUNT(MOTOR_COUNT),
    .TIME_BITS  (TIME_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_empty       (cmd_empty),
    .cmd             (back_cmd),
    .cmd_pop         (cmd_pop),
    .res_full        (res_full),
    .res_push        (res_push),
    .res             (back_res),
    .prot_n          (prot_n),
    .start_times_low (start_low_r),
    .start_times_high(start_high_r)
  );

  msp_queue #(
    .WIDTH($bits(result_t)),
    .DEPTH(2)
  ) u_res_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(back_res),
    .full     (res_full),
    .pop      (out_pop),
    .pop_data (out_res_bits),
    .empty    (out_empty)
  );

  assign out_res             = result_t'(out_res_bits);
  assign out_motor_running   = out_res.motor_running;
  assign out_motor_failed    = out_res.motor_failed;
  assign out_sensor_word     = out_res.sensor_word;
  assign out_sensors_changed = out_res.sensors_changed;
  assign out_motors_changed  = out_res.motors_changed;

endmodule

### design/msp_queue.sv
// ----------------------------------------------------------------------------
// Request and result queue
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module msp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/msp_front.sv
// ----------------------------------------------------------------------------
// Request decoder
// Classifies incoming requests and prepares sensor samples: wiring
// permutation, speed fault bits and masking of the protected bits.
// ----------------------------------------------------------------------------
module msp_front
  import msp_pkg::*;
#(
  parameter int MOTOR_COUNT = 8
) (
  input  logic [2:0]             kind,
  input  logic [2:0]             motor_index,
  input  logic [SENSOR_BITS-1:0] raw_sensors,
  input  logic [3:0]             prot_n,
  output cmd_t                   cmd
);

  logic [SENSOR_BITS-1:0] perm;
  logic [SENSOR_BITS-1:0] clear_mask;
  logic [MAX_MOTORS-1:0]  prot;

  assign perm = permute_sensors(raw_sensors);

  always_comb begin
    clear_mask = '0;
    prot       = '0;
    for (int i = 0; i < MAX_MOTORS; i++) begin
      prot[i] = (4'(i) < prot_n);
      clear_mask[FAULT_BASE_BIT - i] = prot[i];
    end
  end

  always_comb begin
    case (kind)
      KIND_TICK:   cmd.op = CMD_TICK;
      KIND_SAMPLE: cmd.op = CMD_SAMPLE;
      KIND_START:  cmd.op = CMD_START;
      KIND_STOP:   cmd.op = CMD_STOP;
      KIND_CLEAR:  cmd.op = CMD_CLEAR;
      default:     cmd.op = CMD_NOP;
    endcase
    cmd.motor_index = motor_index;
    cmd.index_ok    = ({1'b0, motor_index} < 4'(MOTOR_COUNT));
    cmd.sensors     = perm & ~clear_mask;
    cmd.fault_upd   = prot;
    for (int i = 0; i < MAX_MOTORS; i++) begin
      cmd.fault_val[i] = ~perm[FAULT_BASE_BIT - i];
    end
  end

endmodule

### design/msp_back.sv
// ----------------------------------------------------------------------------
// Motor state engine
// Applies one decoded request per cycle to the motor channels while the
// request queue holds one and the result queue has room, runs the speed
// protection check and forms the result.
module msp_back
  import msp_pkg::*;
#(
  parameter int MOTOR_COUNT = 8,
  parameter int TIME_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_empty,
  input  cmd_t                cmd,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output result_t             res,
  input  logic [3:0]          prot_n,
  input  logic [REG_BITS-1:0] start_times_low,
  input  logic [REG_BITS-1:0] start_times_high
);

  localparam int CMP_W = (TIME_BITS > START_BITS) ? TIME_BITS : START_BITS;

  motor_mode_t            mode_r [MOTOR_COUNT];
  motor_mode_t            mode_nxt [MOTOR_COUNT];
  logic [TIME_BITS-1:0]   count_r [MOTOR_COUNT];
  logic [TIME_BITS-1:0]   count_nxt [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] accel_ready_r, accel_ready_nxt;
  logic [MOTOR_COUNT-1:0] fault_r, fault_nxt;
  logic [SENSOR_BITS-1:0] last_sensors_r, last_sensors_nxt;
  logic [MAX_MOTORS-1:0]  last_running_r;
  logic [START_BITS-1:0]  accel_limit [MOTOR_COUNT];
  logic                   go;

  assign go       = !cmd_empty && !res_full;
  assign cmd_pop  = go;
  assign res_push = go;

  always_comb begin
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      if (i < 4) begin
        accel_limit[i] = start_times_low[START_BITS*(i%4) +: START_BITS];
      end else begin
        accel_limit[i] = start_times_high[START_BITS*(i%4) +: START_BITS];
      end
    end
  end

  always_comb begin
    last_sensors_nxt = last_sensors_r;
    if (cmd.op == CMD_SAMPLE) begin
      last_sensors_nxt = cmd.sensors;
    end
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      mode_nxt[i]        = mode_r[i];
      count_nxt[i]       = count_r[i];
      accel_ready_nxt[i] = accel_ready_r[i];
      fault_nxt[i]       = fault_r[i];
      case (cmd.op)
        CMD_TICK: begin
          if (mode_r[i] == MODE_RUN && !accel_ready_r[i]) begin
            if (CMP_W'(count_r[i]) >= CMP_W'(accel_limit[i])) begin
              accel_ready_nxt[i] = 1'b1;
            end
            count_nxt[i] = count_r[i] + TIME_BITS'(1);
          end
        end
        CMD_SAMPLE: begin
          if (cmd.fault_upd[i]) begin
            fault_nxt[i] = cmd.fault_val[i];
          end
        end
        CMD_START: begin
          if (cmd.index_ok && cmd.motor_index == 3'(i)) begin
            mode_nxt[i]        = MODE_RUN;
            accel_ready_nxt[i] = 1'b0;
            count_nxt[i]       = '0;
          end
        end
        CMD_STOP: begin
          if (cmd.index_ok && cmd.motor_index == 3'(i)) begin
            mode_nxt[i] = MODE_OFF;
          end
        end
        CMD_CLEAR: begin
          if (mode_r[i] == MODE_FAIL) begin
            mode_nxt[i] = MODE_OFF;
          end
        end
        default: begin
        end
      endcase
      if (4'(i) < prot_n && mode_nxt[i] == MODE_RUN && accel_ready_nxt[i] &&
          fault_nxt[i]) begin
        mode_nxt[i] = MODE_FAIL;
      end
    end
  end

  always_comb begin
    res.motor_running = '0;
    res.motor_failed  = '0;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      res.motor_running[i] = (mode_nxt[i] == MODE_RUN);
      res.motor_failed[i]  = (mode_nxt[i] == MODE_FAIL);
    end
    res.sensor_word     = last_sensors_nxt;
    res.sensors_changed = (cmd.op == CMD_SAMPLE) && (cmd.sensors != last_sensors_r);
    res.motors_changed  = (res.motor_running != last_running_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        mode_r[i]  <= MODE_OFF;
        count_r[i] <= '0;
      end
      accel_ready_r  <= '0;
      fault_r        <= '0;
      last_sensors_r <= '0;
      last_running_r <= '0;
    end else if (go) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        mode_r[i]  <= mode_nxt[i];
        count_r[i] <= count_nxt[i];
      end
      accel_ready_r  <= accel_ready_nxt;
      fault_r        <= fault_nxt;
      last_sensors_r <= last_sensors_nxt;
      last_running_r <= res.motor_running;
    end
  end

`ifndef SYNTH
  a_run_fail_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> ((res.motor_running & res.motor_failed) == '0))
    else $error("motor reported both running and failed");

  a_no_sample_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && cmd.op != CMD_SAMPLE) |-> !res.sensors_changed)
    else $error("sensor change flagged on a request that is not a sample");

  a_tick_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (go && cmd.op == CMD_TICK) |=> (($past(accel_ready_r) & ~accel_ready_r) == '0))
    else $error("tick cleared an acceleration ready flag");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> ($stable(accel_ready_r) && $stable(fault_r) && $stable(last_running_r)
             && $stable(last_sensors_r)))
    else $error("motor state changed without a request");
`endif

endmodule
